/* rtl/core/rmt_pkg.sv */
package rmt_pkg;

	localparam int SAMPLE_W = 32;
	localparam int MEDIAN_W = 33;
	localparam int COUNT_W  = 11;

	// what a chain does with the broadcast value
	localparam logic [1:0] OP_NONE    = 2'd0;
	localparam logic [1:0] OP_INSERT  = 2'd1;
	localparam logic [1:0] OP_REPLACE = 2'd2;

	typedef struct packed {
		logic [1:0]                 op;
		logic signed [SAMPLE_W-1:0] value;
	} chain_ctl_t;

endpackage

/* rtl/core/rmt_cell.sv */
module rmt_cell #(
	parameter int INDEX = 0,
	parameter int CW    = 10,
	parameter bit DESC  = 1'b0
) (
	input  logic                                 clk,
	input  rmt_pkg::chain_ctl_t                  ctl,
	input  logic [CW-1:0]                        count,
	input  logic signed [rmt_pkg::SAMPLE_W-1:0]  left_val,
	input  logic                                 left_ahead,
	input  logic signed [rmt_pkg::SAMPLE_W-1:0]  right_val,
	input  logic                                 right_ahead,
	output logic signed [rmt_pkg::SAMPLE_W-1:0]  val,
	output logic                                 ahead
);

	localparam bit HEAD = (INDEX == 0);

	logic signed [rmt_pkg::SAMPLE_W-1:0] val_q;
	logic signed [rmt_pkg::SAMPLE_W-1:0] prev_val;
	logic signed [rmt_pkg::SAMPLE_W-1:0] cur_val;
	logic signed [rmt_pkg::SAMPLE_W-1:0] nxt_val;
	logic                                prev_ahead;
	logic                                cur_ahead;
	logic                                occ;

	assign occ = (CW'(INDEX) < count);

	// ahead: this entry stays in front of the broadcast value
	always_comb begin
		if (DESC) begin
			ahead = occ && (val_q >= ctl.value);
		end else begin
			ahead = occ && (val_q <= ctl.value);
		end
	end

	// replace drops the head, so the window slides one place to the right
	always_comb begin
		if (ctl.op == rmt_pkg::OP_REPLACE) begin
			prev_ahead = HEAD || ahead;
			prev_val   = val_q;
			cur_ahead  = right_ahead;
			cur_val    = right_val;
		end else begin
			prev_ahead = HEAD || left_ahead;
			prev_val   = left_val;
			cur_ahead  = ahead;
			cur_val    = val_q;
		end
		nxt_val = cur_ahead ? cur_val : (prev_ahead ? ctl.value : prev_val);
	end

	always_ff @(posedge clk) begin
		if (ctl.op != rmt_pkg::OP_NONE) begin
			val_q <= nxt_val;
		end
	end

	assign val = val_q;

endmodule

/* rtl/core/rmt_chain.sv */
module rmt_chain #(
	parameter int DEPTH = 513,
	parameter int CW    = 10,
	parameter bit DESC  = 1'b0
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  rmt_pkg::chain_ctl_t                  ctl,
	output logic signed [rmt_pkg::SAMPLE_W-1:0]  top,
	output logic [CW-1:0]                        count
);

	logic signed [rmt_pkg::SAMPLE_W-1:0] vals [DEPTH];
	logic [DEPTH-1:0]                    aheads;
	logic [CW-1:0]                       count_q;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [rmt_pkg::SAMPLE_W-1:0] lv;
		logic signed [rmt_pkg::SAMPLE_W-1:0] rv;
		logic                                la;
		logic                                ra;

		if (i == 0) begin : g_head
			assign lv = '0;
			assign la = 1'b0;
		end else begin : g_left
			assign lv = vals[i-1];
			assign la = aheads[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign rv = '0;
			assign ra = 1'b0;
		end else begin : g_right
			assign rv = vals[i+1];
			assign ra = aheads[i+1];
		end

		rmt_cell #(
			.INDEX (i),
			.CW    (CW),
			.DESC  (DESC)
		) u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.count       (count_q),
			.left_val    (lv),
			.left_ahead  (la),
			.right_val   (rv),
			.right_ahead (ra),
			.val         (vals[i]),
			.ahead       (aheads[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.op == rmt_pkg::OP_INSERT) begin
			count_q <= count_q + CW'(1);
		end
	end

	assign top   = vals[0];
	assign count = count_q;

endmodule

/* rtl/core/running_median_tracker_top.sv */
// running median tracker
// input channel: sample_valid / sample_stall carry one signed 32-bit sample per beat.
// output channel: result_valid / result_stall carry one result per input beat:
// twice the running median, the number of samples held (low 11 bits) and an
// overflow flag that is set when the store was full and the sample was dropped.
// the samples live in two chains of cells, the lower half sorted descending and
// the upper half ascending, so both halves keep their extreme value in cell 0.
// an accepted beat updates one chain, or both when a value moves across halves,
// in the same cycle; the median is then formed from the two head cells (the
// held median is repeated for a dropped sample) and loaded into the output
// register once it is free. no new sample is taken until that median has been
// loaded, since sample_stall stays high while a median is pending.
// the next sample is taken while a result still waits in the output register;
// if the receiver keeps stalling, the following median waits inside and
// sample_stall stays high until the output register frees up.
// reset empties both chains and clears the median to zero; the cell contents
// are not cleared, only the fill counts.
module running_median_tracker_top #(
	parameter int CAPACITY = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 sample_valid,
	output logic                                 sample_stall,
	input  logic signed [rmt_pkg::SAMPLE_W-1:0]  sample,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic signed [rmt_pkg::MEDIAN_W-1:0]  median_times_two,
	output logic [rmt_pkg::COUNT_W-1:0]          sample_count,
	output logic                                 overflow
);

	localparam int HALF = CAPACITY / 2 + 1;
	localparam int CW   = $clog2(HALF + 1);
	localparam int TW   = CW + 1;

	rmt_pkg::chain_ctl_t lower_ctl;
	rmt_pkg::chain_ctl_t upper_ctl;

	logic signed [rmt_pkg::SAMPLE_W-1:0] lower_top;
	logic signed [rmt_pkg::SAMPLE_W-1:0] upper_top;
	logic [CW-1:0]                       lower_count;
	logic [CW-1:0]                       upper_count;
	logic [TW-1:0]                       total;
	logic [TW+rmt_pkg::COUNT_W-1:0]      total_ext;

	logic                                busy_q;
	logic                                ovf_q;
	logic signed [rmt_pkg::MEDIAN_W-1:0] md_q;
	logic                                result_valid_q;
	logic signed [rmt_pkg::MEDIAN_W-1:0] median_q;
	logic [rmt_pkg::COUNT_W-1:0]         count_q;
	logic                                overflow_q;

	logic                                accept;
	logic                                full;
	logic                                below;
	logic                                finish;
	logic signed [rmt_pkg::MEDIAN_W-1:0] med_new;
	logic signed [rmt_pkg::MEDIAN_W-1:0] med_out;

	assign total     = {1'b0, lower_count} + {1'b0, upper_count};
	assign total_ext = {{rmt_pkg::COUNT_W{1'b0}}, total};
	assign full      = (total >= TW'(CAPACITY));
	assign accept    = sample_valid && !busy_q;
	assign below     = ($signed({sample, 1'b0}) < md_q);
	assign finish    = busy_q && (!result_valid_q || !result_stall);

	// pick the chain operations; a move across halves pairs a replace with an insert
	always_comb begin
		lower_ctl.op    = rmt_pkg::OP_NONE;
		lower_ctl.value = sample;
		upper_ctl.op    = rmt_pkg::OP_NONE;
		upper_ctl.value = sample;
		if (accept && !full) begin
			if (lower_count > upper_count) begin
				if (below) begin
					lower_ctl.op    = rmt_pkg::OP_REPLACE;
					upper_ctl.op    = rmt_pkg::OP_INSERT;
					upper_ctl.value = lower_top;
				end else begin
					upper_ctl.op = rmt_pkg::OP_INSERT;
				end
			end else if (lower_count == upper_count) begin
				if (below) begin
					lower_ctl.op = rmt_pkg::OP_INSERT;
				end else begin
					upper_ctl.op = rmt_pkg::OP_INSERT;
				end
			end else begin
				if (below) begin
					lower_ctl.op = rmt_pkg::OP_INSERT;
				end else begin
					upper_ctl.op    = rmt_pkg::OP_REPLACE;
					lower_ctl.op    = rmt_pkg::OP_INSERT;
					lower_ctl.value = upper_top;
				end
			end
		end
	end

	rmt_chain #(
		.DEPTH (HALF),
		.CW    (CW),
		.DESC  (1'b1)
	) u_lower (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (lower_ctl),
		.top    (lower_top),
		.count  (lower_count)
	);

	rmt_chain #(
		.DEPTH (HALF),
		.CW    (CW),
		.DESC  (1'b0)
	) u_upper (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (upper_ctl),
		.top    (upper_top),
		.count  (upper_count)
	);

	always_comb begin
		if (lower_count > upper_count) begin
			med_new = {lower_top, 1'b0};
		end else if (lower_count == upper_count) begin
			med_new = {lower_top[rmt_pkg::SAMPLE_W-1], lower_top}
				+ {upper_top[rmt_pkg::SAMPLE_W-1], upper_top};
		end else begin
			med_new = {upper_top, 1'b0};
		end
		med_out = ovf_q ? md_q : med_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q         <= 1'b0;
			ovf_q          <= 1'b0;
			md_q           <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
				ovf_q  <= full;
			end else if (finish) begin
				busy_q <= 1'b0;
			end
			if (finish) begin
				md_q           <= med_out;
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			median_q   <= med_out;
			count_q    <= total_ext[rmt_pkg::COUNT_W-1:0];
			overflow_q <= ovf_q;
		end
	end

	assign sample_stall     = busy_q;
	assign result_valid     = result_valid_q;
	assign median_times_two = median_q;
	assign sample_count     = count_q;
	assign overflow         = overflow_q;

	a_balanced: assert property (@(posedge clk) disable iff (!arst_n)
		(lower_count == upper_count) || (lower_count == upper_count + CW'(1))
		|| (upper_count == lower_count + CW'(1)))
		else $error("halves out of balance");

	a_grow: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !full |=> total == $past(total) + TW'(1))
		else $error("accepted sample not stored");

	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		accept && full |=> $stable(total))
		else $error("dropped sample changed the store");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total <= TW'(CAPACITY))
		else $error("store beyond capacity");

	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> lower_ctl.op == rmt_pkg::OP_NONE && upper_ctl.op == rmt_pkg::OP_NONE)
		else $error("chain touched while a median is pending");

endmodule
